### rtl/gwp_pkg.sv
// Shared types and constants for the grid wavefront planner.
// No dependencies; imported by the column cell, the top level and the checker.
package gwp_pkg;

    localparam int GRID_COLS = 32;
    localparam int GRID_ROWS = 32;
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int WAVE_W    = 11;
    localparam logic [WAVE_W-1:0] WAVE_MAX = 11'd2047;

    typedef enum logic [1:0] {
        FN_OCC   = 2'd0,
        FN_GOAL  = 2'd1,
        FN_PLAN  = 2'd2,
        FN_TRACE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_PATH = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_STUCK   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_OCC,
        OP_GOAL,
        OP_INIT,
        OP_EXPAND,
        OP_WRITE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              flag;
        logic [WAVE_W-1:0] value;
    } t_cell_ctl;

    typedef struct packed {
        logic              last;
        t_status           status;
        logic [WAVE_W-1:0] wave;
        logic [4:0]        row;
        logic [4:0]        col;
    } t_result;

endpackage

### rtl/grid_wavefront_planner.sv
// Top level: item handshake, plan/trace sequencer and the row of column cells.
// Depends on gwp_pkg and gwp_cell; gwp_checker binds to it.
//
// Occupancy and goal writes give no result. A plan first loads the wave map
// row by row, then for each wave level runs one check, one frontier step across
// all columns and the wave RAM row writes, one row per cycle; last it reads the
// start cell. A trace step makes one wave RAM read per neighbor row. Results wait
// in an output register; a new item is taken once the sequencer is back at rest.
module grid_wavefront_planner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // cell_col[4:0], cell_row[9:5], flag[10]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_col[4:0], out_row[9:5], wave_value[20:10],
                                       // status[22:21]
    output logic        m_axis_tlast   // last
);
    import gwp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CHECK, S_EXPAND, S_WRITE, S_RDS, S_RDS2,
        S_TR0, S_TR1, S_TR2, S_TR3, S_OUT
    } t_state;

    t_state              r_state;
    logic [COL_W-1:0]    r_sc, r_tc;
    logic [ROW_W-1:0]    r_sr, r_tr, r_row;
    logic [WAVE_W-1:0]   r_level;
    t_status             r_st;
    logic [WAVE_W-1:0]   r_cur, r_vl, r_vr, r_vd;
    t_result             r_res;
    logic                r_m_valid;
    t_result             r_m_data;

    t_cell_ctl            w_ctl;
    logic [GRID_ROWS-1:0] w_front [GRID_COLS];
    logic [GRID_ROWS-1:0] w_vis   [GRID_COLS];
    logic [GRID_ROWS-1:0] w_occ   [GRID_COLS];
    logic [GRID_ROWS-1:0] w_goal  [GRID_COLS];
    logic [WAVE_W-1:0]    w_rd    [GRID_COLS];
    logic [GRID_COLS-1:0] w_any;

    logic [4:0]       w_in_col, w_in_row;
    logic             w_in_flag;
    t_func            w_func;
    logic             w_in_grid;
    logic [COL_W-1:0] w_cl_col;
    logic [ROW_W-1:0] w_cl_row;
    logic             w_accept;

    assign w_in_col  = s_axis_tdata[4:0];
    assign w_in_row  = s_axis_tdata[9:5];
    assign w_in_flag = s_axis_tdata[10];
    assign w_func    = t_func'(s_axis_tuser);
    assign w_in_grid = (int'(w_in_col) < GRID_COLS) && (int'(w_in_row) < GRID_ROWS);
    assign w_cl_col  = (int'(w_in_col) < GRID_COLS) ? w_in_col[COL_W-1:0] : COL_W'(GRID_COLS-1);
    assign w_cl_row  = (int'(w_in_row) < GRID_ROWS) ? w_in_row[ROW_W-1:0] : ROW_W'(GRID_ROWS-1);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept  = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < GRID_COLS; g++) begin : g_col
            logic [GRID_ROWS-1:0] w_fl, w_fr;
            if (g == 0) begin : g_l0
                assign w_fl = '0;
            end else begin : g_l1
                assign w_fl = w_front[g-1];
            end
            if (g == GRID_COLS-1) begin : g_r0
                assign w_fr = '0;
            end else begin : g_r1
                assign w_fr = w_front[g+1];
            end
            gwp_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_col_id  (COL_W'(g)),
                .i_ctl     (w_ctl),
                .i_front_l (w_fl),
                .i_front_r (w_fr),
                .o_front   (w_front[g]),
                .o_vis     (w_vis[g]),
                .o_occ     (w_occ[g]),
                .o_goal    (w_goal[g]),
                .o_rd      (w_rd[g])
            );
            assign w_any[g] = |w_front[g];
        end
    endgenerate

    // cell control
    always_comb begin
        w_ctl       = '0;
        w_ctl.op    = OP_NONE;
        w_ctl.value = r_level + WAVE_W'(1);
        w_ctl.row   = r_row;
        case (r_state)
            S_IDLE: begin
                w_ctl.col  = w_in_col[COL_W-1:0];
                w_ctl.row  = w_in_row[ROW_W-1:0];
                w_ctl.flag = w_in_flag;
                if (w_accept && w_in_grid && w_func == FN_OCC)  w_ctl.op = OP_OCC;
                if (w_accept && w_in_grid && w_func == FN_GOAL) w_ctl.op = OP_GOAL;
            end
            S_INIT:   w_ctl.op = OP_INIT;
            S_EXPAND: w_ctl.op = OP_EXPAND;
            S_WRITE:  w_ctl.op = OP_WRITE;
            S_RDS:    w_ctl.row = r_sr;
            S_TR0:    w_ctl.row = r_tr;
            S_TR1:    w_ctl.row = r_tr - ROW_W'(1);
            S_TR2:    w_ctl.row = r_tr + ROW_W'(1);
            default: ;
        endcase
    end

    // trace step decision
    logic [WAVE_W-1:0] w_vu, w_low;
    logic [COL_W-1:0]  w_bc;
    logic [ROW_W-1:0]  w_br;
    logic              w_moved;
    t_result           w_tres;
    always_comb begin
        w_vu    = w_rd[r_tc];
        w_low   = r_cur;
        w_bc    = r_tc;
        w_br    = r_tr;
        w_moved = 1'b0;
        if (r_cur != WAVE_W'(1)) begin
            if (r_tc != '0 && r_vl > WAVE_W'(1) && r_vl < w_low) begin
                w_low = r_vl; w_bc = r_tc - COL_W'(1); w_br = r_tr; w_moved = 1'b1;
            end
            if (int'(r_tc) != GRID_COLS-1 && r_vr > WAVE_W'(1) && r_vr < w_low) begin
                w_low = r_vr; w_bc = r_tc + COL_W'(1); w_br = r_tr; w_moved = 1'b1;
            end
            if (r_tr != '0 && r_vd > WAVE_W'(1) && r_vd < w_low) begin
                w_low = r_vd; w_bc = r_tc; w_br = r_tr - ROW_W'(1); w_moved = 1'b1;
            end
            if (int'(r_tr) != GRID_ROWS-1 && w_vu > WAVE_W'(1) && w_vu < w_low) begin
                w_low = w_vu; w_bc = r_tc; w_br = r_tr + ROW_W'(1); w_moved = 1'b1;
            end
        end
        w_tres.col    = 5'(r_tc);
        w_tres.row    = 5'(r_tr);
        w_tres.wave   = r_cur;
        w_tres.status = ST_OK;
        w_tres.last   = 1'b1;
        if (!w_goal[r_tc][r_tr]) begin
            if (!w_moved) begin
                w_tres.status = ST_STUCK;
                w_tres.last   = 1'b0;
            end else begin
                w_tres.col  = 5'(w_bc);
                w_tres.row  = 5'(w_br);
                w_tres.wave = w_low;
                w_tres.last = w_goal[w_bc][w_br];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tc      <= '0;
            r_tr      <= '0;
            r_level   <= WAVE_W'(2);
            r_m_valid <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_OUT) r_m_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_func == FN_PLAN) begin
                        r_sc    <= w_cl_col;
                        r_sr    <= w_cl_row;
                        r_tc    <= w_cl_col;
                        r_tr    <= w_cl_row;
                        r_row   <= '0;
                        r_level <= WAVE_W'(2);
                        r_state <= S_INIT;
                    end else if (w_accept && w_func == FN_TRACE) begin
                        r_state <= S_TR0;
                    end
                end
                S_INIT: begin
                    r_row <= r_row + ROW_W'(1);
                    if (int'(r_row) == GRID_ROWS-1) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_row <= '0;
                    if (w_vis[r_sc][r_sr]) begin
                        r_st    <= w_occ[r_sc][r_sr] ? ST_BLOCKED : ST_OK;
                        r_state <= S_RDS;
                    end else if (r_level >= WAVE_MAX) begin
                        r_st    <= ST_NO_PATH;
                        r_state <= S_RDS;
                    end else begin
                        r_state <= S_EXPAND;
                    end
                end
                S_EXPAND: r_state <= S_WRITE;
                S_WRITE: begin
                    r_row <= r_row + ROW_W'(1);
                    if (int'(r_row) == GRID_ROWS-1) begin
                        r_level <= r_level + WAVE_W'(1);
                        if (|w_any) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_st    <= ST_NO_PATH;
                            r_state <= S_RDS;
                        end
                    end
                end
                S_RDS:  r_state <= S_RDS2;
                S_RDS2: begin
                    r_res.col    <= 5'(r_sc);
                    r_res.row    <= 5'(r_sr);
                    r_res.wave   <= w_rd[r_sc];
                    r_res.status <= r_st;
                    r_res.last   <= w_goal[r_sc][r_sr];
                    r_state      <= S_OUT;
                end
                S_TR0: r_state <= S_TR1;
                S_TR1: begin
                    r_cur   <= w_rd[r_tc];
                    r_vl    <= (r_tc != '0) ? w_rd[r_tc - COL_W'(1)] : '0;
                    r_vr    <= (int'(r_tc) != GRID_COLS-1) ? w_rd[r_tc + COL_W'(1)] : '0;
                    r_state <= S_TR2;
                end
                S_TR2: begin
                    r_vd    <= w_rd[r_tc];
                    r_state <= S_TR3;
                end
                S_TR3: begin
                    r_res <= w_tres;
                    if (!w_goal[r_tc][r_tr] && w_moved) begin
                        r_tc <= w_bc;
                        r_tr <= w_br;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_data.status, r_m_data.wave, r_m_data.row, r_m_data.col};
    assign m_axis_tlast  = r_m_data.last;

endmodule

### rtl/gwp_cell.sv
// One grid column: occupancy, goal, visited and frontier bits plus a wave RAM.
// Depends on gwp_pkg; frontier bits pass to the neighbor columns every cycle.
module gwp_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [gwp_pkg::COL_W-1:0]     i_col_id,
    input  gwp_pkg::t_cell_ctl            i_ctl,
    input  logic [gwp_pkg::GRID_ROWS-1:0] i_front_l,
    input  logic [gwp_pkg::GRID_ROWS-1:0] i_front_r,
    output logic [gwp_pkg::GRID_ROWS-1:0] o_front,
    output logic [gwp_pkg::GRID_ROWS-1:0] o_vis,
    output logic [gwp_pkg::GRID_ROWS-1:0] o_occ,
    output logic [gwp_pkg::GRID_ROWS-1:0] o_goal,
    output logic [gwp_pkg::WAVE_W-1:0]    o_rd
);
    import gwp_pkg::*;

    logic [GRID_ROWS-1:0] r_occ, r_goal, r_vis, r_front;
    logic [GRID_ROWS-1:0] w_new;
    logic [WAVE_W-1:0]    r_mem [GRID_ROWS];
    logic [WAVE_W-1:0]    w_init;
    logic [WAVE_W-1:0]    r_rd;

    assign w_new  = (i_front_l | i_front_r | (r_front << 1) | (r_front >> 1)) & ~r_vis;
    assign w_init = r_occ[i_ctl.row] ? WAVE_W'(1) : (r_goal[i_ctl.row] ? WAVE_W'(2) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_goal  <= '0;
            r_vis   <= '0;
            r_front <= '0;
        end else begin
            case (i_ctl.op)
                OP_OCC: begin
                    if (i_ctl.col == i_col_id) r_occ[i_ctl.row] <= i_ctl.flag;
                end
                OP_GOAL: begin
                    if (i_ctl.col == i_col_id) r_goal[i_ctl.row] <= i_ctl.flag;
                end
                OP_INIT: begin
                    r_vis   <= r_occ | r_goal;
                    r_front <= r_goal & ~r_occ;
                end
                OP_EXPAND: begin
                    r_front <= w_new;
                    r_vis   <= r_vis | w_new;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_INIT)
            r_mem[i_ctl.row] <= w_init;
        else if (i_ctl.op == OP_WRITE && r_front[i_ctl.row])
            r_mem[i_ctl.row] <= i_ctl.value;
        r_rd <= r_mem[i_ctl.row];
    end

    assign o_front = r_front;
    assign o_vis   = r_vis;
    assign o_occ   = r_occ;
    assign o_goal  = r_goal;
    assign o_rd    = r_rd;

endmodule

### rtl/gwp_checker.sv
// Port-level checks for grid_wavefront_planner, attached by bind.
// Depends on gwp_pkg for status codes.
module gwp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import gwp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[22:21] == ST_BLOCKED |-> m_axis_tdata[20:10] == 11'd1)
        else $error("blocked start without occupied value");

    a_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[22:21] == ST_STUCK |-> !m_axis_tlast)
        else $error("stuck trace flagged as goal");

    a_nopath: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[22:21] == ST_NO_PATH |-> m_axis_tdata[20:10] == 11'd0)
        else $error("no path with nonzero start value");

endmodule

bind grid_wavefront_planner gwp_checker u_gwp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### sim/testbench.sv
// Self-checking testbench for grid_wavefront_planner: directed table, then random
// grid edits, plans and trace walks checked against an in-bench predictor.
// Depends on gwp_pkg and the grid_wavefront_planner RTL.
`timescale 1ns / 100ps

module testbench;
    import gwp_pkg::*;

    typedef struct packed {
        logic [4:0]  col;
        logic [4:0]  row;
        logic [10:0] wave;
        logic [1:0]  status;
        logic        last;
    } t_answer;

    typedef struct {
        t_func      fn;
        logic [4:0] col;
        logic [4:0] row;
        logic       flag;
        logic       known;
        t_answer    ans;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // cell_col[4:0], cell_row[9:5], flag[10]
    logic [1:0]  s_axis_tuser = '0;  // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;       // out_col[4:0], out_row[9:5], wave[20:10], status[22:21]
    logic        m_axis_tlast;

    grid_wavefront_planner uut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    bit          occ [1024];
    bit          goal [1024];
    int unsigned wave [1024];
    int unsigned tr_col, tr_row;
    bit          planned;

    t_answer     pending_answers [$];
    int          errors, n_plans, n_traces, n_results, n_stuck, n_nopath;
    bit          idle_ok = 1'b1;
    int          hold_cycles;

    function automatic int unsigned idx(int unsigned c, int unsigned r);
        return c * 32 + r;
    endfunction

    function automatic bit nbr(int unsigned c, int unsigned r, int k,
                               output int unsigned nc, output int unsigned nr);
        nc = c;
        nr = r;
        case (k)
            0: begin if (c == 0) return 0; nc = c - 1; end
            1: begin if (c == 31) return 0; nc = c + 1; end
            2: begin if (r == 0) return 0; nr = r - 1; end
            default: begin if (r == 31) return 0; nr = r + 1; end
        endcase
        return 1;
    endfunction

    function automatic t_status run_wave(int unsigned sc, int unsigned sr);
        int unsigned s, lvl, nc, nr, i;
        bit changed;
        s = idx(sc, sr);
        for (int j = 0; j < 1024; j++) wave[j] = occ[j] ? 1 : (goal[j] ? 2 : 0);
        lvl = 2;
        forever begin
            changed = 0;
            if (wave[s] > 0) return occ[s] ? ST_BLOCKED : ST_OK;
            if (lvl >= 2047) return ST_NO_PATH;
            for (int c = 0; c < 32; c++)
                for (int r = 0; r < 32; r++) begin
                    if (wave[idx(c, r)] != lvl) continue;
                    for (int k = 0; k < 4; k++) begin
                        if (!nbr(c, r, k, nc, nr)) continue;
                        i = idx(nc, nr);
                        if (!occ[i] && wave[i] == 0) begin
                            wave[i] = lvl + 1;
                            changed = 1;
                        end
                    end
                end
            lvl++;
            if (!changed) return ST_NO_PATH;
        end
    endfunction

    function automatic bit predict_planner(t_func fn, int unsigned c, int unsigned r, bit f,
                                           output t_answer a);
        int unsigned cur, low, bc, br, nc, nr, v;
        t_status st;
        a = '0;
        case (fn)
            FN_OCC: begin occ[idx(c, r)] = f; return 0; end
            FN_GOAL: begin goal[idx(c, r)] = f; return 0; end
            FN_PLAN: begin
                st = run_wave(c, r);
                tr_col = c;
                tr_row = r;
                planned = 1;
                a = '{5'(c), 5'(r), 11'(wave[idx(c, r)]), st, goal[idx(c, r)]};
                return 1;
            end
            default: begin
                cur = idx(tr_col, tr_row);
                low = wave[cur];
                if (goal[cur]) begin
                    a = '{5'(tr_col), 5'(tr_row), 11'(low), ST_OK, 1'b1};
                    return 1;
                end
                bc = tr_col;
                br = tr_row;
                if (low != 1)
                    for (int k = 0; k < 4; k++) begin
                        if (!nbr(tr_col, tr_row, k, nc, nr)) continue;
                        v = wave[idx(nc, nr)];
                        if (v > 1 && v < low) begin
                            low = v;
                            bc = nc;
                            br = nr;
                        end
                    end
                if (bc == tr_col && br == tr_row) begin
                    a = '{5'(tr_col), 5'(tr_row), 11'(wave[cur]), ST_STUCK, 1'b0};
                    return 1;
                end
                tr_col = bc;
                tr_row = br;
                cur = idx(bc, br);
                a = '{5'(bc), 5'(br), 11'(wave[cur]), ST_OK, goal[cur]};
                return 1;
            end
        endcase
    endfunction

    task automatic send_item(t_func fn, logic [4:0] c, logic [4:0] r, logic f,
                             bit known = 0, t_answer ans = '0, bit may_idle = 1);
        t_answer a;
        if (fn == FN_TRACE && !planned) return;
        while (may_idle && idle_ok && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, f, r, c};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_planner(fn, c, r, f, a)) begin
            if (known && a != ans) begin
                $display("%0t: table entry disagrees, expected %h predicted %h", $time, ans, a);
                errors++;
            end
            if (fn == FN_PLAN) n_plans++; else n_traces++;
            pending_answers = {pending_answers, a};
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else
            m_axis_tready <= !(idle_ok && $urandom_range(99) < 10);
    end

    always @(posedge i_clk) begin
        t_answer a, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tdata[20:10],
                    m_axis_tdata[22:21], m_axis_tlast};
            n_results++;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                a = pending_answers.pop_front();
                if (got.status == ST_STUCK) n_stuck++;
                if (got.status == ST_NO_PATH) n_nopath++;
                if (got.col != a.col) begin
                    $display("%0t: out_col expected %0d actual %0d", $time, a.col, got.col);
                    errors++;
                end
                if (got.row != a.row) begin
                    $display("%0t: out_row expected %0d actual %0d", $time, a.row, got.row);
                    errors++;
                end
                if (got.wave != a.wave) begin
                    $display("%0t: wave_value expected %0d actual %0d", $time, a.wave, got.wave);
                    errors++;
                end
                if (got.status != a.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, a.status,
                             got.status);
                    errors++;
                end
                if (got.last != a.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, a.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #400ms;
        $display("grid_wavefront_planner test failed");
        $finish;
    end

    t_row directed [$];

    initial begin
        int unsigned pick, c, r;
        directed = '{
            '{FN_PLAN,  5'd0,  5'd0,  1'b0, 1'b1, '{5'd0, 5'd0, 11'd0, ST_NO_PATH, 1'b0}},
            '{FN_TRACE, 5'd0,  5'd0,  1'b0, 1'b1, '{5'd0, 5'd0, 11'd0, ST_STUCK, 1'b0}},
            '{FN_GOAL,  5'd31, 5'd31, 1'b1, 1'b0, '0},
            '{FN_PLAN,  5'd31, 5'd31, 1'b0, 1'b1, '{5'd31, 5'd31, 11'd2, ST_OK, 1'b1}},
            '{FN_TRACE, 5'd0,  5'd0,  1'b0, 1'b1, '{5'd31, 5'd31, 11'd2, ST_OK, 1'b1}},
            '{FN_PLAN,  5'd0,  5'd0,  1'b1, 1'b0, '0},
            '{FN_TRACE, 5'd31, 5'd31, 1'b1, 1'b0, '0},
            '{FN_TRACE, 5'd0,  5'd0,  1'b0, 1'b0, '0},
            '{FN_OCC,   5'd0,  5'd0,  1'b1, 1'b0, '0},
            '{FN_PLAN,  5'd0,  5'd0,  1'b0, 1'b1, '{5'd0, 5'd0, 11'd1, ST_BLOCKED, 1'b0}},
            '{FN_TRACE, 5'd0,  5'd0,  1'b0, 1'b1, '{5'd0, 5'd0, 11'd1, ST_STUCK, 1'b0}},
            '{FN_OCC,   5'd0,  5'd0,  1'b0, 1'b0, '0},
            '{FN_OCC,   5'd30, 5'd31, 1'b1, 1'b0, '0},
            '{FN_OCC,   5'd31, 5'd30, 1'b1, 1'b0, '0},
            '{FN_PLAN,  5'd0,  5'd31, 1'b0, 1'b1, '{5'd0, 5'd31, 11'd0, ST_NO_PATH, 1'b0}},
            '{FN_GOAL,  5'd31, 5'd31, 1'b0, 1'b0, '0},
            '{FN_GOAL,  5'd16, 5'd0,  1'b1, 1'b0, '0},
            '{FN_GOAL,  5'd17, 5'd0,  1'b1, 1'b0, '0},
            '{FN_PLAN,  5'd16, 5'd2,  1'b0, 1'b0, '0},
            '{FN_TRACE, 5'd0,  5'd0,  1'b0, 1'b0, '0},
            '{FN_TRACE, 5'd0,  5'd0,  1'b0, 1'b0, '0},
            '{FN_GOAL,  5'd16, 5'd0,  1'b0, 1'b0, '0},
            '{FN_TRACE, 5'd0,  5'd0,  1'b0, 1'b0, '0},
            '{FN_OCC,   5'd30, 5'd31, 1'b0, 1'b0, '0},
            '{FN_OCC,   5'd31, 5'd30, 1'b0, 1'b0, '0}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i])
            send_item(directed[i].fn, directed[i].col, directed[i].row, directed[i].flag,
                      directed[i].known, directed[i].ans);
        drain();

        // long receiver hold while the sender keeps offering items
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++) send_item(FN_TRACE, 5'd0, 5'd0, 1'b0);
        send_item(FN_PLAN, 5'd10, 5'd10, 1'b0, 0, '0, 0);
        for (int i = 0; i < 6; i++) send_item(FN_TRACE, 5'd0, 5'd0, 1'b0, 0, '0, 0);
        drain();

        // random scenes: sparse obstacles, a few goals, a plan, then a trace walk
        for (int scene = 0; scene < 12; scene++) begin
            if (scene == 4) idle_ok = 1'b0;
            if (scene == 7) idle_ok = 1'b1;
            for (int i = 0; i < 28; i++) begin
                pick = $urandom_range(99);
                c = $urandom_range(31);
                r = $urandom_range(31);
                if (pick < 70) send_item(FN_OCC, 5'(c), 5'(r), $urandom_range(3) != 0);
                else if (pick < 85) send_item(FN_GOAL, 5'(c), 5'(r), 1'($urandom_range(1)));
                else send_item(t_func'($urandom_range(3)), 5'(c), 5'(r),
                               1'($urandom_range(1)));
            end
            if (scene % 3 == 0)
                for (int i = 0; i < 3; i++)
                    send_item(FN_GOAL, 5'($urandom_range(31)), 5'($urandom_range(31)), 1'b1);
            send_item(FN_PLAN, 5'($urandom_range(31)), 5'($urandom_range(31)),
                      1'($urandom_range(1)));
            for (int i = 0; i < 18; i++)
                send_item(FN_TRACE, 5'($urandom_range(31)), 5'($urandom_range(31)),
                          1'($urandom_range(1)));
            if (scene == 5) drain();
        end
        drain();
        $display("covered %0d plans and %0d trace steps, %0d results (%0d stuck, %0d no path)",
                 n_plans, n_traces, n_results, n_stuck, n_nopath);
        if (errors == 0 && pending_answers.size() == 0)
            $display("grid_wavefront_planner test passed");
        else
            $display("grid_wavefront_planner test failed");
        $finish;
    end
endmodule
